[rtl/spr_pkg.sv]
package spr_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 8;
    localparam int unsigned SLOT_NUM_W     = 6;
    localparam int unsigned RECORD_LEN     = 15;
    localparam int unsigned BUF_LEN        = 16;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [3:0] ST_IDLE_BYTE    = 4'd0;
    localparam logic [3:0] ST_PACKET_BYTE  = 4'd1;
    localparam logic [3:0] ST_STORED_KNOWN = 4'd2;
    localparam logic [3:0] ST_STORED_NEW   = 4'd3;
    localparam logic [3:0] ST_BAD_SUM      = 4'd4;
    localparam logic [3:0] ST_TABLE_FULL   = 4'd5;
    localparam logic [3:0] ST_LINE_ERROR   = 4'd6;
    localparam logic [3:0] ST_TICK         = 4'd7;
    localparam logic [3:0] ST_READ         = 4'd8;

    localparam logic [4:0] POS_IDLE   = 5'd31;
    localparam logic [4:0] POS_LAST   = 5'd16;
    localparam logic [4:0] POS_LEN    = 5'd17;
    localparam logic [7:0] SYNC_BYTE  = 8'hFF;
    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] RELOAD_DEF = 8'd255;

    typedef logic [RECORD_LEN-1:0][7:0] record_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
        logic       line_error;
        logic [2:0] read_slot;
        logic [3:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [3:0] status;
        logic [2:0] slot_used;
        logic [7:0] read_data;
        logic [7:0] read_timeout;
    } out_item_t;

    typedef struct packed {
        logic                  valid;
        logic                  is_read;
        logic [15:0]           key;
        logic [3:0]            index;
        logic                  hit_match;
        logic [SLOT_NUM_W-1:0] match_slot;
        logic                  hit_free;
        logic [SLOT_NUM_W-1:0] free_slot;
        logic [7:0]            data;
        logic [7:0]            timeout;
    } token_t;

    typedef struct packed {
        logic                  tick;
        logic                  wr_en;
        logic [SLOT_NUM_W-1:0] wr_slot;
        logic [7:0]            wr_timeout;
        record_t               wr_record;
    } cell_ctl_t;

endpackage

[rtl/spr_cell.sv]
module spr_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  spr_pkg::cell_ctl_t ctl,
    input  spr_pkg::token_t    tok_in,
    output spr_pkg::token_t    tok_out
);
    import spr_pkg::*;

    localparam logic [SLOT_NUM_W-1:0] MY_SLOT = SLOT_NUM_W'(INDEX);

    record_t    rec_reg;
    logic [7:0] tmo_reg;
    token_t     tok_reg;
    token_t     tok_next;

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid)
        begin
            if (tok_in.is_read)
            begin
                if (tok_in.key == 16'(INDEX))
                begin
                    tok_next.timeout = tmo_reg;
                    tok_next.data    = (tok_in.index < 4'(RECORD_LEN)) ?
                                       rec_reg[tok_in.index] : 8'd0;
                end
            end
            else
            begin
                if (!tok_in.hit_match && {rec_reg[1], rec_reg[2]} == tok_in.key)
                begin
                    tok_next.hit_match  = 1'b1;
                    tok_next.match_slot = MY_SLOT;
                end
                if (!tok_in.hit_free && tmo_reg == 8'd0)
                begin
                    tok_next.hit_free  = 1'b1;
                    tok_next.free_slot = MY_SLOT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
            tmo_reg <= '0;
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (ctl.wr_en && ctl.wr_slot == MY_SLOT)
            begin
                rec_reg <= ctl.wr_record;
                tmo_reg <= ctl.wr_timeout;
            end
            else if (ctl.tick && tmo_reg != 8'd0)
            begin
                tmo_reg <= tmo_reg - 8'd1;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

[rtl/sensor_packet_receiver_table_core.sv]
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_data (in_item_t)
// out       output     out_valid / out_stall out_data (out_item_t)
// cfg       input      cfg_valid / cfg_ready cfg_data (timeout reload)
//
// Packet bytes, line errors and ticks give a result without a slot walk; unused operations give none.
// A read and the last byte of a good packet send a token through the slot
// cells, one per cycle; for a packet the chosen slot, if any, is then written.
// Reset clears all slot records and timeouts at once; no clearing pass.
// Two result registers let one item be taken while a result waits on out_stall.
module sensor_packet_receiver_table_core #(
    parameter int unsigned SLOT_COUNT = spr_pkg::SLOT_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  spr_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output spr_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);
    import spr_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_WAIT
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] reload_reg;
    logic [BUF_LEN-1:0][7:0] buf_reg;
    logic       buf_we;

    logic       out_valid_reg, out_valid_next;
    logic       skid_valid_reg, skid_valid_next;
    out_item_t  out_data_reg, out_data_next;
    out_item_t  skid_data_reg, skid_data_next;

    logic       accept;
    logic       take;
    logic       push;
    out_item_t  res;
    token_t     launch;
    token_t     chain [SLOT_COUNT+1];
    token_t     tok_end;
    cell_ctl_t  ctl;

    assign accept    = in_valid && !in_stall;
    assign take      = out_valid_reg && !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign chain[0] = launch;
    assign tok_end  = chain[SLOT_COUNT];

    for (genvar g = 0; g < SLOT_COUNT; g++)
    begin : g_cell
        spr_cell #(
            .INDEX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        buf_we     = 1'b0;
        push       = 1'b0;
        res        = '0;
        launch     = '0;
        ctl        = '0;

        for (int k = 0; k < RECORD_LEN; k++)
        begin
            ctl.wr_record[k] = buf_reg[k+1];
        end
        ctl.wr_timeout = reload_reg;

        if (accept)
        begin
            unique case (in_data.operation)
                OP_BYTE:
                begin
                    push = 1'b1;
                    priority if (in_data.line_error)
                    begin
                        res.status = ST_LINE_ERROR;
                    end
                    else if (pos_reg >= POS_LEN)
                    begin
                        res.status = ST_IDLE_BYTE;
                        if (sum_reg == SYNC_BYTE && in_data.rx_byte == START_BYTE)
                        begin
                            pos_next = '0;
                            sum_next = '0;
                        end
                        else
                        begin
                            sum_next = in_data.rx_byte;
                        end
                    end
                    else if (pos_reg == POS_LAST)
                    begin
                        pos_next = POS_IDLE;
                        if (in_data.rx_byte != sum_reg)
                        begin
                            res.status = ST_BAD_SUM;
                        end
                        else
                        begin
                            push           = 1'b0;
                            launch.valid   = 1'b1;
                            launch.is_read = 1'b0;
                            launch.key     = {buf_reg[2], buf_reg[3]};
                            state_next     = S_WAIT;
                        end
                    end
                    else
                    begin
                        res.status = ST_PACKET_BYTE;
                        buf_we     = 1'b1;
                        pos_next   = pos_reg + 5'd1;
                        sum_next   = sum_reg + in_data.rx_byte;
                    end
                end
                OP_TICK:
                begin
                    push       = 1'b1;
                    res.status = ST_TICK;
                    ctl.tick   = 1'b1;
                end
                OP_READ:
                begin
                    launch.valid   = 1'b1;
                    launch.is_read = 1'b1;
                    launch.key     = {13'd0, in_data.read_slot};
                    launch.index   = in_data.read_index;
                    state_next     = S_WAIT;
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_WAIT && tok_end.valid)
        begin
            push       = 1'b1;
            state_next = S_IDLE;
            if (tok_end.is_read)
            begin
                res.status       = ST_READ;
                res.slot_used    = tok_end.key[2:0];
                res.read_data    = tok_end.data;
                res.read_timeout = tok_end.timeout;
            end
            else if (tok_end.hit_match)
            begin
                res.status    = ST_STORED_KNOWN;
                res.slot_used = tok_end.match_slot[2:0];
                ctl.wr_en     = 1'b1;
                ctl.wr_slot   = tok_end.match_slot;
            end
            else if (tok_end.hit_free)
            begin
                res.status    = ST_STORED_NEW;
                res.slot_used = tok_end.free_slot[2:0];
                ctl.wr_en     = 1'b1;
                ctl.wr_slot   = tok_end.free_slot;
            end
            else
            begin
                res.status = ST_TABLE_FULL;
            end
        end
    end

    // result queue: out register in front, skid register behind
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = res;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_reg        <= POS_IDLE;
            sum_reg        <= '0;
            reload_reg     <= RELOAD_DEF;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                reload_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
        if (buf_we)
        begin
            buf_reg[pos_reg[3:0]] <= in_data.rx_byte;
        end
    end

endmodule
